// ===== hw/rtl/imucf_pkg.sv =====
`default_nettype none

package imucf_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GYRO_GAIN   = 3'd0;
  localparam logic [2:0] REG_MAG_LOW     = 3'd1;
  localparam logic [2:0] REG_MAG_HIGH    = 3'd2;
  localparam logic [2:0] REG_KEEP_WEIGHT = 3'd3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [15:0] GYRO_GAIN_RST   = 16'd1281;
  localparam logic [16:0] MAG_LOW_RST     = 17'd8192;
  localparam logic [16:0] MAG_HIGH_RST    = 17'd32768;
  localparam logic [16:0] KEEP_WEIGHT_RST = 17'd64225;
  localparam logic [16:0] WEIGHT_ONE      = 17'd65536;

  localparam int unsigned CORDIC_STEPS_DEF    = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  // Fraction bits of the arctangent table and CORDIC angle accumulator
  localparam int unsigned TABLE_FRAC = 24;
  localparam int unsigned STEP_IDX_W = 5;
  localparam int unsigned XY_W       = 44;
  localparam int unsigned Z_W        = 35;
  localparam int unsigned TILT_W     = 33;

  localparam logic signed [Z_W-1:0] DEG180_Q24 = 35'sd3019898880;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [29:0] atan_q24(input logic [STEP_IDX_W-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'd754974720;
      5'd1:    r = 30'd445687602;
      5'd2:    r = 30'd235489088;
      5'd3:    r = 30'd119537938;
      5'd4:    r = 30'd60000934;
      5'd5:    r = 30'd30029717;
      5'd6:    r = 30'd15018523;
      5'd7:    r = 30'd7509720;
      5'd8:    r = 30'd3754917;
      5'd9:    r = 30'd1877466;
      5'd10:   r = 30'd938734;
      5'd11:   r = 30'd469367;
      5'd12:   r = 30'd234684;
      5'd13:   r = 30'd117342;
      5'd14:   r = 30'd58671;
      5'd15:   r = 30'd29335;
      5'd16:   r = 30'd14668;
      5'd17:   r = 30'd7334;
      5'd18:   r = 30'd3667;
      5'd19:   r = 30'd1833;
      5'd20:   r = 30'd917;
      5'd21:   r = 30'd458;
      5'd22:   r = 30'd229;
      5'd23:   r = 30'd115;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imucf_cordic.sv =====
`default_nettype none

module imucf_cordic #(
  parameter int unsigned CORDIC_STEPS    = imucf_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = imucf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [15:0]                  y_i,
  input  wire logic signed [15:0]                  x_i,
  output logic                                     done_o,
  output logic signed [imucf_pkg::TILT_W-1:0]      tilt_o
);

  localparam int unsigned SH = imucf_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [imucf_pkg::Z_W-1:0] HALF = imucf_pkg::Z_W'(1) <<< (SH - 1);
  localparam logic [imucf_pkg::STEP_IDX_W-1:0] LAST =
    imucf_pkg::STEP_IDX_W'(CORDIC_STEPS - 1);

  logic signed [imucf_pkg::XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [imucf_pkg::Z_W-1:0]  z_q, z_d;
  logic [imucf_pkg::STEP_IDX_W-1:0]  cnt_q, cnt_d;
  logic                              busy_q, busy_d, done_q, done_d;

  logic signed [16:0]                 x17, y17, xa, ya;
  logic signed [imucf_pkg::XY_W-1:0] xs, ys;
  logic signed [imucf_pkg::Z_W-1:0]  step_ang, zr, zsh;

  assign x17 = {x_i[15], x_i};
  assign y17 = {y_i[15], y_i};
  assign xa  = x17[16] ? -x17 : x17;
  assign ya  = x17[16] ? -y17 : y17;

  assign xs       = x_q >>> cnt_q;
  assign ys       = y_q >>> cnt_q;
  assign step_ang = $signed({5'd0, imucf_pkg::atan_q24(cnt_q)});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      // Fold the left half plane onto the right, starting at +/-180 degrees
      x_d    = {{3{xa[16]}}, xa, 24'd0};
      y_d    = {{3{ya[16]}}, ya, 24'd0};
      if (x17[16]) begin
        z_d = y17[16] ? -imucf_pkg::DEG180_Q24 : imucf_pkg::DEG180_Q24;
      end else begin
        z_d = '0;
      end
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!y_q[imucf_pkg::XY_W-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + step_ang;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - step_ang;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign zr     = z_q + HALF;
  assign zsh    = zr >>> SH;
  assign tilt_o = zsh[imucf_pkg::TILT_W-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/imu_complementary_filter.sv =====
`default_nettype none
// Path: S_GX, S_GY and S_RL add the gyro terms; when the accelerometer blend applies,
// S_CORD, S_B1, S_B2 and S_B3 run for pitch and then roll, and S_DONE hands off the result.
// Throughput: one sample at a time; the input stalls until the result is handed off, with
// the roll arctangent overlapping the pitch blend on the shared multiplier.
// Reset: angles clear to zero, registers take their default values, no result pending.

module imu_complementary_filter #(
  parameter int unsigned CORDIC_STEPS    = imucf_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = imucf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [imucf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [imucf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [15:0]                   acc_x_i,
  input  wire logic signed [15:0]                   acc_y_i,
  input  wire logic signed [15:0]                   acc_z_i,
  input  wire logic signed [15:0]                   gyro_x_i,
  input  wire logic signed [15:0]                   gyro_y_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [31:0]                        pitch_out_o,
  output logic signed [31:0]                        roll_out_o,
  output logic                                      accel_applied_o
);

  localparam int unsigned SH = imucf_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [33:0] GHALF = 34'sd1 <<< (SH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GX   = 4'd1;
  localparam logic [3:0] S_GY   = 4'd2;
  localparam logic [3:0] S_RL   = 4'd3;
  localparam logic [3:0] S_CORD = 4'd4;
  localparam logic [3:0] S_B1   = 4'd5;
  localparam logic [3:0] S_B2   = 4'd6;
  localparam logic [3:0] S_B3   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  logic [15:0] gain_q;
  logic [16:0] mag_lo_q, mag_hi_q, keep_q;

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic signed [15:0] ax_d, ay_d, az_d, gx_d, gy_d;
  logic signed [31:0] pitch_q, pitch_d, roll_q, roll_d;
  logic               apply_q, apply_d, sel_q, sel_d;
  logic signed [imucf_pkg::TILT_W-1:0] tilt_q, tilt_d;
  logic signed [50:0] prod_q, acc_q, acc_d;

  logic signed [31:0] out_pitch_q, out_pitch_d, out_roll_q, out_roll_d;
  logic               out_app_q, out_app_d, out_valid_q, out_valid_d;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  logic        in_acc, cord_start, cord_done;
  logic signed [15:0] cord_y;
  logic signed [imucf_pkg::TILT_W-1:0] cord_tilt;

  logic [16:0] abs_x, abs_y, abs_z, mag;
  logic        in_window;
  logic [16:0] keep_c, weight_c;
  logic signed [33:0] gsum, gdelta;
  logic signed [31:0] ang_sel;
  logic signed [50:0] bsum, bsh;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= imucf_pkg::GYRO_GAIN_RST;
      mag_lo_q <= imucf_pkg::MAG_LOW_RST;
      mag_hi_q <= imucf_pkg::MAG_HIGH_RST;
      keep_q   <= imucf_pkg::KEEP_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imucf_pkg::REG_GYRO_GAIN:   gain_q   <= cfg_wdata_i[15:0];
        imucf_pkg::REG_MAG_LOW:     mag_lo_q <= cfg_wdata_i;
        imucf_pkg::REG_MAG_HIGH:    mag_hi_q <= cfg_wdata_i;
        imucf_pkg::REG_KEEP_WEIGHT: keep_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign abs_x = ax_q[15] ? 17'(-$signed({ax_q[15], ax_q})) : {1'b0, ax_q};
  assign abs_y = ay_q[15] ? 17'(-$signed({ay_q[15], ay_q})) : {1'b0, ay_q};
  assign abs_z = az_q[15] ? 17'(-$signed({az_q[15], az_q})) : {1'b0, az_q};
  assign mag       = abs_x + abs_y + abs_z;
  assign in_window = (mag > mag_lo_q) && (mag < mag_hi_q);

  assign keep_c   = (keep_q > imucf_pkg::WEIGHT_ONE) ? imucf_pkg::WEIGHT_ONE : keep_q;
  assign weight_c = imucf_pkg::WEIGHT_ONE - keep_c;

  // Round the Q.24 gyro product down to the angle format
  assign gsum   = $signed(prod_q[33:0]) + GHALF;
  assign gdelta = gsum >>> SH;

  assign ang_sel = sel_q ? roll_q : pitch_q;

  assign bsum = acc_q + prod_q + 51'sd32768;
  assign bsh  = bsum >>> 16;

  always_comb begin
    mul_a = {gx_q[15], {16{gx_q[15]}}, gx_q};
    mul_b = $signed({2'b00, gain_q});
    case (state_q)
      S_GY: begin
        mul_a = {gy_q[15], {16{gy_q[15]}}, gy_q};
      end
      S_B1: begin
        mul_a = {ang_sel[31], ang_sel};
        mul_b = $signed({1'b0, keep_c});
      end
      S_B2: begin
        mul_a = tilt_q;
        mul_b = $signed({1'b0, weight_c});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Pitch tilt uses atan2(ay, az), roll tilt atan2(ax, az)
  assign cord_y = (state_q == S_CORD) ? ax_q : ay_q;

  imucf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (az_q),
    .done_o  (cord_done),
    .tilt_o  (cord_tilt)
  );

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    pitch_d     = pitch_q;
    roll_d      = roll_q;
    apply_d     = apply_q;
    sel_d       = sel_q;
    tilt_d      = tilt_q;
    acc_d       = acc_q;
    cord_start  = 1'b0;
    out_pitch_d = out_pitch_q;
    out_roll_d  = out_roll_q;
    out_app_d   = out_app_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ax_d    = acc_x_i;
          ay_d    = acc_y_i;
          az_d    = acc_z_i;
          gx_d    = gyro_x_i;
          gy_d    = gyro_y_i;
          state_d = S_GX;
        end
      end
      S_GX: begin
        state_d = S_GY;
      end
      S_GY: begin
        pitch_d = imucf_pkg::sat32({{3{pitch_q[31]}}, pitch_q} + {gdelta[33], gdelta});
        apply_d = in_window;
        state_d = S_RL;
      end
      S_RL: begin
        roll_d = imucf_pkg::sat32({{3{roll_q[31]}}, roll_q} - {gdelta[33], gdelta});
        sel_d  = 1'b0;
        if (apply_q) begin
          cord_start = 1'b1;
          state_d    = S_CORD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CORD: begin
        if (cord_done) begin
          tilt_d = cord_tilt;
          // Start the roll arctangent behind the pitch blend
          cord_start = !sel_q;
          state_d    = S_B1;
        end
      end
      S_B1: begin
        state_d = S_B2;
      end
      S_B2: begin
        acc_d   = prod_q;
        state_d = S_B3;
      end
      S_B3: begin
        if (sel_q) begin
          roll_d  = imucf_pkg::sat32(bsh[34:0]);
          state_d = S_DONE;
        end else begin
          pitch_d = imucf_pkg::sat32(bsh[34:0]);
          sel_d   = 1'b1;
          state_d = S_CORD;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_pitch_d = pitch_q;
          out_roll_d  = roll_q;
          out_app_d   = apply_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pitch_q     <= '0;
      roll_q      <= '0;
      out_valid_q <= 1'b0;
      apply_q     <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pitch_q     <= pitch_d;
      roll_q      <= roll_d;
      out_valid_q <= out_valid_d;
      apply_q     <= apply_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    az_q        <= az_d;
    gx_q        <= gx_d;
    gy_q        <= gy_d;
    tilt_q      <= tilt_d;
    acc_q       <= acc_d;
    prod_q      <= mul_p;
    out_pitch_q <= out_pitch_d;
    out_roll_q  <= out_roll_d;
    out_app_q   <= out_app_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign pitch_out_o     = out_pitch_q;
  assign roll_out_o      = out_roll_q;
  assign accel_applied_o = out_app_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after taking a sample");

  a_cordic_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == S_CORD)
    else $error("arctangent finished outside its wait state");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result beat raised outside the finish state");

  a_applied_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORD |-> apply_q)
    else $error("tilt computed without a blend pending");

endmodule

`default_nettype wire
